FILE: design/fsne_pkg.sv
// Shared constants, types and helpers for the format string number emitter.
package fsne_pkg;

   localparam int CHAR_W     = 8;
   localparam int ARG_W      = 64;
   localparam int DIGIT_W    = 4;
   localparam int DEC_DIGITS = 20;
   localparam int HEX_DIGITS = ARG_W / DIGIT_W;
   localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
   localparam int CONV_CNT_W = $clog2(ARG_W);
   localparam int DCNT_W     = $clog2(DEC_DIGITS + 1);
   localparam int HCNT_W     = $clog2(HEX_DIGITS);
   localparam int QUEUE_LEN  = 3;
   localparam int QCNT_W     = $clog2(QUEUE_LEN + 1);

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_PCT   = 8'h25;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] SPEC_C     = 8'h63;
   localparam logic [CHAR_W-1:0] SPEC_D     = 8'h64;
   localparam logic [CHAR_W-1:0] SPEC_U     = 8'h75;
   localparam logic [CHAR_W-1:0] SPEC_X     = 8'h78;

   localparam logic [DIGIT_W-1:0] ASCII_DIGIT_HI = 4'h3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUEUE,
      ST_CONV,
      ST_SKIP,
      ST_DEC,
      ST_HEX
   } fsne_state_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_DEC,
      MODE_HEX
   } fsne_mode_type;

   typedef struct packed {
      logic             load;
      logic             shift_out;
      logic [ARG_W-1:0] value;
   } fsne_bcd_ctl_type;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] msd;
   } fsne_bcd_sts_type;

   // lowercase hex digit for one nibble
   function automatic logic [CHAR_W-1:0] hex_ascii(input logic [DIGIT_W-1:0] nib);
      logic [CHAR_W-1:0] r;
      if (nib < 4'd10) begin
         r = {ASCII_DIGIT_HI, nib};
      end else begin
         r = 8'h57 + {4'h0, nib};
      end
      return r;
   endfunction

endpackage

FILE: design/format_string_number_emitter.sv
// Top level of the format string number emitter: decode, sequencing, output word.
//
// One format byte enters per input word, with a 64-bit argument; the block
// works on one input word at a time and takes the next once the last output
// word of the current one sits in the output register. A plain byte sends one
// output byte (two for a newline). %x sends sixteen hex digits, one a cycle
// while the output is not stalled, out of a nibble shift register.
// %d and %u go through a bit-serial shift-and-add-three converter: the accept
// cycle, the conversion of all 64 argument bits, a check that it is done, the
// leading zeros dropped (up to 19) and a step to stop skipping, then the
// digits sent. Dropped zeros and sent digits always add up to twenty, and
// the minus sign of %d goes out while the conversion runs. Output stalls
// just stretch the emission phases.
// A format byte that produces nothing (percent, or zero) is absorbed in its
// accept cycle. The output byte that closes the work of an input word carries
// tlast.
module format_string_number_emitter (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // [7:0] format_char, [71:8] argument
   input  logic [fsne_pkg::CHAR_W+fsne_pkg::ARG_W-1:0] req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // [7:0] out_char
   output logic [fsne_pkg::CHAR_W-1:0]               rsp_tdata,
   output logic                                      rsp_tlast
);
   import fsne_pkg::*;

   fsne_state_type state_ff, state_in;
   fsne_mode_type  mode_ff, mode_in;

   logic                          pct_ff, pct_in;
   logic [QUEUE_LEN*CHAR_W-1:0]   queue_ff, queue_in;
   logic [QCNT_W-1:0]             qcnt_ff, qcnt_in;
   logic [ARG_W-1:0]              hex_ff, hex_in;
   logic [HCNT_W-1:0]             hcnt_ff, hcnt_in;
   logic [DCNT_W-1:0]             dcnt_ff, dcnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]             rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [CHAR_W-1:0]             fmt_char;
   logic [ARG_W-1:0]              arg;
   logic                          accept;
   logic                          out_free;
   logic                          emit;
   logic [CHAR_W-1:0]             emit_byte;
   logic                          emit_last;
   logic                          skip_zero;

   // decode of the incoming byte
   logic [QUEUE_LEN*CHAR_W-1:0]   dec_queue;
   logic [QCNT_W-1:0]             dec_qcnt;
   fsne_mode_type                 dec_mode;
   logic                          dec_pct;
   logic [ARG_W-1:0]              dec_value;

   fsne_bcd_ctl_type              bcd_ctl;
   fsne_bcd_sts_type              bcd_sts;

   fsne_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .ctl   (bcd_ctl),
      .sts   (bcd_sts)
   );

   assign fmt_char   = req_tdata[CHAR_W-1:0];
   assign arg        = req_tdata[CHAR_W +: ARG_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   // output register can take a word this cycle
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   // drop a leading zero, but always keep the final digit
   assign skip_zero  = (bcd_sts.msd == '0) && (dcnt_ff > DCNT_W'(1));

   // Decode one format byte into up to three literal bytes (sent first,
   // lowest byte first) and an optional conversion.
   always_comb begin
      dec_queue = '0;
      dec_qcnt  = '0;
      dec_mode  = MODE_NONE;
      dec_pct   = pct_ff;
      dec_value = arg;
      if (!pct_ff) begin
         if (fmt_char == CHAR_NUL) begin
            dec_pct = 1'b0;
         end else if (fmt_char == CHAR_PCT) begin
            dec_pct = 1'b1;
         end else if (fmt_char == CHAR_LF) begin
            dec_queue = {CHAR_NUL, CHAR_LF, CHAR_CR};
            dec_qcnt  = QCNT_W'(2);
         end else begin
            dec_queue = {CHAR_NUL, CHAR_NUL, fmt_char};
            dec_qcnt  = QCNT_W'(1);
         end
      end else begin
         dec_pct = 1'b0;
         case (fmt_char)
            CHAR_NUL: begin
               dec_qcnt = '0;
            end
            SPEC_D: begin
               dec_mode = MODE_DEC;
               if (arg[ARG_W-1]) begin
                  dec_queue = {CHAR_NUL, CHAR_NUL, CHAR_MINUS};
                  dec_qcnt  = QCNT_W'(1);
                  dec_value = ~arg + 1'b1;
               end
            end
            SPEC_U: begin
               dec_mode = MODE_DEC;
            end
            SPEC_X: begin
               dec_mode = MODE_HEX;
            end
            SPEC_C: begin
               if (arg[CHAR_W-1:0] == CHAR_LF) begin
                  dec_queue = {CHAR_NUL, CHAR_LF, CHAR_CR};
                  dec_qcnt  = QCNT_W'(2);
               end else begin
                  dec_queue = {CHAR_NUL, CHAR_NUL, arg[CHAR_W-1:0]};
                  dec_qcnt  = QCNT_W'(1);
               end
            end
            CHAR_PCT: begin
               dec_queue = {CHAR_NUL, CHAR_NUL, CHAR_PCT};
               dec_qcnt  = QCNT_W'(1);
            end
            default: begin
               // unknown specifier: echo the percent and the byte
               if (fmt_char == CHAR_LF) begin
                  dec_queue = {CHAR_LF, CHAR_CR, CHAR_PCT};
                  dec_qcnt  = QCNT_W'(3);
               end else begin
                  dec_queue = {CHAR_NUL, fmt_char, CHAR_PCT};
                  dec_qcnt  = QCNT_W'(2);
               end
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (dec_qcnt != '0) begin
                  state_in = ST_QUEUE;
               end else if (dec_mode == MODE_DEC) begin
                  state_in = ST_CONV;
               end else if (dec_mode == MODE_HEX) begin
                  state_in = ST_HEX;
               end
            end
         end
         ST_QUEUE: begin
            if (out_free && (qcnt_ff == QCNT_W'(1))) begin
               case (mode_ff)
                  MODE_DEC: state_in = ST_CONV;
                  MODE_HEX: state_in = ST_HEX;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONV: begin
            if (bcd_sts.done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!skip_zero) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (out_free && (dcnt_ff == DCNT_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         ST_HEX: begin
            if (out_free && (hcnt_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and output word per state
   always_comb begin
      mode_in           = mode_ff;
      pct_in            = pct_ff;
      queue_in          = queue_ff;
      qcnt_in           = qcnt_ff;
      hex_in            = hex_ff;
      hcnt_in           = hcnt_ff;
      dcnt_in           = dcnt_ff;
      emit              = 1'b0;
      emit_byte         = CHAR_NUL;
      emit_last         = 1'b0;
      bcd_ctl.load      = 1'b0;
      bcd_ctl.shift_out = 1'b0;
      bcd_ctl.value     = dec_value;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pct_in       = dec_pct;
               queue_in     = dec_queue;
               qcnt_in      = dec_qcnt;
               mode_in      = dec_mode;
               hex_in       = arg;
               hcnt_in      = HCNT_W'(HEX_DIGITS - 1);
               bcd_ctl.load = (dec_mode == MODE_DEC);
            end
         end
         ST_QUEUE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = queue_ff[CHAR_W-1:0];
               emit_last = (qcnt_ff == QCNT_W'(1)) && (mode_ff == MODE_NONE);
               queue_in  = {{CHAR_W{1'b0}}, queue_ff[QUEUE_LEN*CHAR_W-1:CHAR_W]};
               qcnt_in   = qcnt_ff - 1'b1;
            end
         end
         ST_CONV: begin
            if (bcd_sts.done) begin
               dcnt_in = DCNT_W'(DEC_DIGITS);
            end
         end
         ST_SKIP: begin
            if (skip_zero) begin
               bcd_ctl.shift_out = 1'b1;
               dcnt_in           = dcnt_ff - 1'b1;
            end
         end
         ST_DEC: begin
            if (out_free) begin
               emit              = 1'b1;
               emit_byte         = {ASCII_DIGIT_HI, bcd_sts.msd};
               emit_last         = (dcnt_ff == DCNT_W'(1));
               bcd_ctl.shift_out = 1'b1;
               dcnt_in           = dcnt_ff - 1'b1;
            end
         end
         ST_HEX: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = hex_ascii(hex_ff[ARG_W-1 -: DIGIT_W]);
               emit_last = (hcnt_ff == '0);
               hex_in    = {hex_ff[ARG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               hcnt_in   = hcnt_ff - 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // output register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pct_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_NONE;
      end else begin
         state_ff     <= state_in;
         pct_ff       <= pct_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
      queue_ff    <= queue_in;
      qcnt_ff     <= qcnt_in;
      hex_ff      <= hex_in;
      hcnt_ff     <= hcnt_in;
      dcnt_ff     <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/fsne_bcd.sv
// Bit-serial binary to BCD converter (shift and add three), digit shift-out.
module fsne_bcd (
   input  logic                      clock,
   input  logic                      reset,
   input  fsne_pkg::fsne_bcd_ctl_type ctl,
   output fsne_pkg::fsne_bcd_sts_type sts
);
   import fsne_pkg::*;

   logic [ARG_W-1:0]      bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CONV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [BCD_W-1:0]      adjusted;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adjusted[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adjusted[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctl.load) begin
         bin_in  = ctl.value;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adjusted[BCD_W-2:0], bin_ff[ARG_W-1]};
         bin_in = {bin_ff[ARG_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CONV_CNT_W'(ARG_W - 1)) begin
            busy_in = 1'b0;
         end
      end else if (ctl.shift_out) begin
         bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign sts.done = ~busy_ff;
   assign sts.msd  = bcd_ff[BCD_W-1 -: DIGIT_W];

endmodule
